FILE: hdl/tmwht_pkg.sv
// Types and codes shared by the window hit-test block.
package tmwht_pkg;

	// Field widths fixed by the item format
	localparam int unsigned COORD_W = 16;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned WNUM_W  = 7;

	// Command kinds
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_CLICK = 1'b1;

	// Result status codes
	localparam logic [STAT_W-1:0] ST_HIT    = 2'd0;
	localparam logic [STAT_W-1:0] ST_MISS   = 2'd1;
	localparam logic [STAT_W-1:0] ST_LOADED = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

	// Command beat
	typedef struct packed {
		logic               kind;
		logic [COORD_W-1:0] left_x;
		logic [COORD_W-1:0] right_x;
		logic [COORD_W-1:0] bottom_y;
		logic [COORD_W-1:0] top_y;
		logic [COORD_W-1:0] point_x;
		logic [COORD_W-1:0] point_y;
	} tmwht_cmd_t;

	// Result beat
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [WNUM_W-1:0] window_number;
	} tmwht_rsp_t;

	// Stored rectangle
	typedef struct packed {
		logic [COORD_W-1:0] top_y;
		logic [COORD_W-1:0] bottom_y;
		logic [COORD_W-1:0] right_x;
		logic [COORD_W-1:0] left_x;
	} tmwht_rect_t;

endpackage

FILE: hdl/topmost_window_hit_test_core.sv
// Top level: window table with topmost-hit search and raise-to-front ranks.
//
//  channel | signals                       | direction | payload
//  --------+-------------------------------+-----------+-------------------
//  command | cmd_valid, cmd_ready, cmd     | in        | tmwht_cmd_t
//  result  | res_valid, res_ready, res     | out       | tmwht_rsp_t
//
// A load writes the table in the accept cycle, then hands on its result.
// A click on an empty table goes straight to the result; otherwise it makes one
// pass over the rectangle memory through the shared bound/rank comparator, and
// on a hit a second pass over the rank memory (one read per cycle).
// Reset empties the table (window count to zero); memories are not cleared.
// cmd_ready is low while an item is in work; a result waiting in the output
// register holds the sequencer only at the moment it would hand off the next.
module topmost_window_hit_test_core
	import tmwht_pkg::*;
#(
	parameter int unsigned MAX_WINDOWS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	output logic       cmd_ready,
	input  tmwht_cmd_t cmd,
	output logic       res_valid,
	input  logic       res_ready,
	output tmwht_rsp_t res
);

	localparam int unsigned IDX_W  = (MAX_WINDOWS > 1) ? $clog2(MAX_WINDOWS) : 1;
	localparam int unsigned CNT_W  = $clog2(MAX_WINDOWS + 1);
	localparam int unsigned WIDE_W = (CNT_W > WNUM_W) ? CNT_W : WNUM_W;

	// Sequencer states
	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_SCAN     = 3'd1;
	localparam logic [2:0] S_SCAN_END = 3'd2;
	localparam logic [2:0] S_UPD      = 3'd3;
	localparam logic [2:0] S_UPD_END  = 3'd4;
	localparam logic [2:0] S_UPD_FIN  = 3'd5;
	localparam logic [2:0] S_RESP     = 3'd6;

	logic [2:0] state_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] last_idx;
	logic idx_last;

	logic [COORD_W-1:0] px_q;
	logic [COORD_W-1:0] py_q;

	logic found_q;
	logic [IDX_W-1:0] best_q;
	logic [IDX_W-1:0] best_rank_q;

	logic vld_s1;
	logic [IDX_W-1:0] idx_s1;
	tmwht_rect_t rect_s1;
	logic [IDX_W-1:0] rank_s1;

	tmwht_rsp_t res_q;
	tmwht_rsp_t out_q;
	logic out_valid_q;

	// Memories
	tmwht_rect_t rect_mem [MAX_WINDOWS];
	logic [IDX_W-1:0] rank_mem [MAX_WINDOWS];

	logic cmd_acc;
	logic table_full;
	logic rect_we;
	logic rank_we;
	logic [IDX_W-1:0] rank_waddr;
	logic [IDX_W-1:0] rank_wdata;
	tmwht_rect_t cmd_rect;

	logic inside_pt;
	logic rank_gt;
	logic cand;
	logic found_n;
	logic [IDX_W-1:0] best_n;
	logic [IDX_W-1:0] best_rank_n;
	logic [WIDE_W-1:0] load_num;
	logic [WIDE_W-1:0] hit_num;
	logic out_free;

	assign cmd_acc    = cmd_valid && cmd_ready;
	assign cmd_ready  = (state_q == S_IDLE);
	assign table_full = (count_q == CNT_W'(MAX_WINDOWS));
	assign last_idx   = IDX_W'(count_q - CNT_W'(1));
	assign idx_last   = (idx_q == last_idx);
	assign out_free   = !out_valid_q || res_ready;
	assign load_num   = WIDE_W'(count_q) + WIDE_W'(1);
	assign hit_num    = WIDE_W'(best_q) + WIDE_W'(1);

	assign cmd_rect.left_x   = cmd.left_x;
	assign cmd_rect.right_x  = cmd.right_x;
	assign cmd_rect.bottom_y = cmd.bottom_y;
	assign cmd_rect.top_y    = cmd.top_y;

	// Shared compare unit: point in rectangle, rank above current reference
	assign inside_pt = (rect_s1.left_x <= px_q) && (px_q <= rect_s1.right_x) &&
		(rect_s1.bottom_y <= py_q) && (py_q <= rect_s1.top_y);
	assign rank_gt = (rank_s1 > best_rank_q);

	// Running topmost candidate during the scan
	always_comb begin
		cand        = vld_s1 && inside_pt && (!found_q || rank_gt);
		found_n     = found_q || cand;
		best_n      = cand ? idx_s1 : best_q;
		best_rank_n = cand ? rank_s1 : best_rank_q;
	end

	// Memory write port selection
	always_comb begin
		rect_we    = 1'b0;
		rank_we    = 1'b0;
		rank_waddr = idx_s1;
		rank_wdata = rank_s1 - IDX_W'(1);
		unique case (state_q) inside
			S_IDLE: begin
				if (cmd_acc && (cmd.kind == KIND_LOAD) && !table_full) begin
					rect_we    = 1'b1;
					rank_we    = 1'b1;
					rank_waddr = IDX_W'(count_q);
					rank_wdata = IDX_W'(count_q);
				end
			end
			S_UPD, S_UPD_END: begin
				rank_we = vld_s1 && rank_gt;
			end
			S_UPD_FIN: begin
				rank_we    = 1'b1;
				rank_waddr = best_q;
				rank_wdata = last_idx;
			end
			S_SCAN, S_SCAN_END, S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	// Memory ports: registered read at idx_q, one write each
	always_ff @(posedge clk) begin
		rect_s1 <= rect_mem[idx_q];
		rank_s1 <= rank_mem[idx_q];
		if (rect_we) begin
			rect_mem[IDX_W'(count_q)] <= cmd_rect;
		end
		if (rank_we) begin
			rank_mem[rank_waddr] <= rank_wdata;
		end
	end

	// Sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			vld_s1 <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					idx_q   <= '0;
					found_q <= 1'b0;
					if (cmd_acc) begin
						if (cmd.kind == KIND_LOAD) begin
							if (!table_full) begin
								count_q <= count_q + CNT_W'(1);
							end
							state_q <= S_RESP;
						end else if (count_q == '0) begin
							state_q <= S_RESP;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					vld_s1  <= 1'b1;
					found_q <= found_n;
					if (idx_last) begin
						state_q <= S_SCAN_END;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_SCAN_END: begin
					found_q <= found_n;
					idx_q   <= '0;
					state_q <= found_n ? S_UPD : S_RESP;
				end
				S_UPD: begin
					vld_s1 <= 1'b1;
					if (idx_last) begin
						state_q <= S_UPD_END;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_UPD_END: begin
					state_q <= S_UPD_FIN;
				end
				S_UPD_FIN: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: point, best candidate, pending result
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (cmd_acc) begin
			px_q <= cmd.point_x;
			py_q <= cmd.point_y;
			if (cmd.kind == KIND_LOAD) begin
				if (table_full) begin
					res_q.status        <= ST_FULL;
					res_q.window_number <= '0;
				end else begin
					res_q.status        <= ST_LOADED;
					res_q.window_number <= load_num[WNUM_W-1:0];
				end
			end else begin
				res_q.status        <= ST_MISS;
				res_q.window_number <= '0;
			end
		end
		if ((state_q == S_SCAN) || (state_q == S_SCAN_END)) begin
			best_q      <= best_n;
			best_rank_q <= best_rank_n;
		end
		if (state_q == S_UPD_FIN) begin
			res_q.status        <= ST_HIT;
			res_q.window_number <= hit_num[WNUM_W-1:0];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_RESP) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_RESP) && out_free) begin
			out_q <= res_q;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

FILE: test/tb_topmost_window_hit_test_core.sv
// Self-checking testbench for the window hit-test core: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_topmost_window_hit_test_core;
	import tmwht_pkg::*;

	localparam int unsigned NWIN         = 64;
	localparam int unsigned RANK_W       = $clog2(NWIN);
	localparam int unsigned RANDOM_ITEMS = 1300;
	localparam int unsigned IDLE_LIMIT   = 5000;
	localparam int unsigned HOLD_AT      = 500;  // command beats before the long result hold-off
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int          N_DIR        = 21;

	typedef enum int unsigned {RX_OPEN, RX_COIN, RX_SPARSE} rx_mode_e;

	// One directed row; typed rows carry their answer, the rest use the window table model
	typedef struct {
		logic        kind;
		int unsigned lx, rx, by, ty, px, py;
		bit          typed;
		logic [1:0]  st;
		int unsigned num;
	} dir_row_t;

	logic       clk;
	logic       arst_n;
	logic       cmd_valid;
	logic       cmd_ready;
	tmwht_cmd_t cmd;
	logic       res_valid;
	logic       res_ready;
	tmwht_rsp_t res;

	// Shadow window table: rectangles, stacking ranks, count
	tmwht_rect_t       win_rect [NWIN];
	logic [RANK_W-1:0] win_rank [NWIN];
	logic [WNUM_W-1:0] win_count;

	tmwht_rsp_t  awaited_q [$];
	int unsigned mismatches;
	int unsigned cmd_beats;
	int unsigned idle_cycles;

	//                kind        lx     rx     by     ty     px     py   typed status   num
	dir_row_t dir_table [N_DIR] = '{
		'{KIND_CLICK, 0,     0,     0,     0,     0,     0,     1, ST_MISS,   0}, // empty table
		'{KIND_CLICK, 65535, 65535, 65535, 65535, 65535, 65535, 1, ST_MISS,   0}, // empty, far corner
		'{KIND_LOAD,  0,     65535, 0,     65535, 65535, 65535, 1, ST_LOADED, 1}, // whole screen
		'{KIND_CLICK, 0,     0,     0,     0,     0,     0,     1, ST_HIT,    1},
		'{KIND_CLICK, 0,     0,     0,     0,     65535, 65535, 1, ST_HIT,    1},
		'{KIND_LOAD,  100,   50,    0,     65535, 0,     0,     1, ST_LOADED, 2}, // x inverted
		'{KIND_CLICK, 0,     0,     0,     0,     75,    10,    1, ST_HIT,    1}, // never hits 2
		'{KIND_LOAD,  0,     65535, 9,     8,     1,     2,     1, ST_LOADED, 3}, // y inverted
		'{KIND_CLICK, 0,     0,     0,     0,     0,     8,     1, ST_HIT,    1},
		'{KIND_LOAD,  500,   500,   500,   500,   0,     0,     1, ST_LOADED, 4}, // one pixel
		'{KIND_CLICK, 0,     0,     0,     0,     500,   500,   1, ST_HIT,    4},
		'{KIND_CLICK, 0,     0,     0,     0,     501,   500,   1, ST_HIT,    1},
		'{KIND_CLICK, 0,     0,     0,     0,     500,   500,   0, ST_HIT,    0}, // 1 now on top
		'{KIND_LOAD,  1000,  2000,  1000,  2000,  23130, 23130, 1, ST_LOADED, 5},
		'{KIND_CLICK, 0,     0,     0,     0,     2000,  1000,  0, ST_HIT,    0}, // corner
		'{KIND_CLICK, 0,     0,     0,     0,     999,   1000,  0, ST_HIT,    0}, // left of edge
		'{KIND_CLICK, 0,     0,     0,     0,     2001,  2000,  0, ST_HIT,    0}, // right of edge
		'{KIND_LOAD,  65534, 65535, 65534, 65535, 0,     0,     1, ST_LOADED, 6}, // top-right
		'{KIND_CLICK, 0,     0,     0,     0,     65535, 65534, 0, ST_HIT,    0},
		'{KIND_CLICK, 65535, 0,     65535, 0,     65534, 65535, 0, ST_HIT,    0}, // junk bounds
		'{KIND_CLICK, 0,     0,     0,     0,     0,     65535, 0, ST_HIT,    0}
	};

	topmost_window_hit_test_core #(
		.MAX_WINDOWS(NWIN)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Apply one command to the shadow table and return the answer it gives
	function automatic tmwht_rsp_t window_table_step(input tmwht_cmd_t c);
		tmwht_rsp_t        r;
		logic              found;
		int unsigned       top_idx;
		logic [RANK_W-1:0] hit_rank;
		r.status        = ST_MISS;
		r.window_number = '0;
		found           = 1'b0;
		top_idx         = 0;
		if (c.kind == KIND_LOAD) begin
			if (win_count >= NWIN) begin
				r.status = ST_FULL;
			end else begin
				win_rect[win_count].left_x   = c.left_x;
				win_rect[win_count].right_x  = c.right_x;
				win_rect[win_count].bottom_y = c.bottom_y;
				win_rect[win_count].top_y    = c.top_y;
				win_rank[win_count]          = win_count[RANK_W-1:0];
				win_count                    = win_count + 1'b1;
				r.status                     = ST_LOADED;
				r.window_number              = win_count;
			end
		end else begin
			// topmost containing window, all bounds inclusive
			for (int i = 0; i < int'(win_count); i++) begin
				if (win_rect[i].left_x <= c.point_x && c.point_x <= win_rect[i].right_x &&
				    win_rect[i].bottom_y <= c.point_y && c.point_y <= win_rect[i].top_y &&
				    (!found || win_rank[i] > win_rank[top_idx])) begin
					top_idx = i;
					found   = 1'b1;
				end
			end
			// raise to front: those above drop one rank
			if (found) begin
				hit_rank = win_rank[top_idx];
				for (int i = 0; i < int'(win_count); i++) begin
					if (win_rank[i] > hit_rank)
						win_rank[i] = win_rank[i] - 1'b1;
				end
				win_rank[top_idx] = RANK_W'(win_count - 1'b1);
				r.status          = ST_HIT;
				r.window_number   = WNUM_W'(top_idx + 1);
			end
		end
		return r;
	endfunction

	// Coordinate with extra weight on both ends of the range
	function automatic logic [COORD_W-1:0] rand_coord();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			default: return COORD_W'($urandom());
		endcase
	endfunction

	// Beat with every field random
	function automatic tmwht_cmd_t noise_beat();
		tmwht_cmd_t b;
		b.kind     = 1'($urandom());
		b.left_x   = rand_coord();
		b.right_x  = rand_coord();
		b.bottom_y = rand_coord();
		b.top_y    = rand_coord();
		b.point_x  = rand_coord();
		b.point_y  = rand_coord();
		return b;
	endfunction

	// Bound pair {lo, hi}: wide sorted, narrow, or inverted
	function automatic logic [2*COORD_W-1:0] rand_span(input int unsigned shape);
		logic [COORD_W-1:0] a;
		logic [COORD_W-1:0] b;
		logic [COORD_W-1:0] hi;
		int unsigned        w;
		a = rand_coord();
		b = rand_coord();
		if (shape < 4)
			return (a <= b) ? {a, b} : {b, a};
		if (shape < 8) begin
			w  = $urandom_range(0, 3000);
			hi = (int'(a) + w > 65535) ? '1 : a + COORD_W'(w);
			return {a, hi};
		end
		return (a > b) ? {a, b} : {b, a};
	endfunction

	// Point coordinate on, inside, or just past a bound pair
	function automatic logic [COORD_W-1:0] pick_near(input logic [COORD_W-1:0] lo,
	                                                 input logic [COORD_W-1:0] hi);
		int v;
		if (lo > hi)
			return rand_coord();
		case ($urandom_range(0, 9))
			0, 1: v = int'(lo);
			2, 3: v = int'(hi);
			4: v = int'(lo) - 1;
			5: v = int'(hi) + 1;
			default: v = int'($urandom_range(hi, lo));
		endcase
		if (v < 0)
			v = 0;
		if (v > 65535)
			v = 65535;
		return COORD_W'(v);
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
	                               input int unsigned want);
		$display("%0t: %s got %0d, want %0d", $time, what, got, want);
		mismatches++;
	endtask

	// Hold a command beat until accepted, then queue its answer
	task automatic offer_beat(input tmwht_cmd_t beat, input bit typed, input tmwht_rsp_t want);
		tmwht_rsp_t predicted;
		cmd_valid <= 1'b1;
		cmd       <= beat;
		do @(posedge clk); while (!cmd_ready);
		predicted = window_table_step(beat);
		awaited_q.insert(awaited_q.size(), typed ? want : predicted);
		cmd_beats++;
	endtask

	// Reset and command stimulus
	initial begin
		tmwht_cmd_t  beat;
		tmwht_rsp_t  want;
		int unsigned burst_left;
		int unsigned gap;
		int unsigned shape;
		int unsigned k;
		logic [2*COORD_W-1:0] xs;
		logic [2*COORD_W-1:0] ys;
		win_count   = '0;
		cmd_beats   = 0;
		burst_left  = 0;
		arst_n    <= 1'b0;
		cmd_valid <= 1'b0;
		cmd       <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < N_DIR; i++) begin
			beat                = '0;
			beat.kind           = dir_table[i].kind;
			beat.left_x         = COORD_W'(dir_table[i].lx);
			beat.right_x        = COORD_W'(dir_table[i].rx);
			beat.bottom_y       = COORD_W'(dir_table[i].by);
			beat.top_y          = COORD_W'(dir_table[i].ty);
			beat.point_x        = COORD_W'(dir_table[i].px);
			beat.point_y        = COORD_W'(dir_table[i].py);
			want.status         = dir_table[i].st;
			want.window_number  = WNUM_W'(dir_table[i].num);
			offer_beat(beat, dir_table[i].typed, want);
		end

		// random loads and clicks in bursts; the table fills, then loads bounce
		want = '0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 40);
				gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 20);
				if (gap != 0) begin
					cmd_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst_left--;
			beat = noise_beat();
			if ($urandom_range(0, 99) < ((win_count < NWIN) ? 25 : 12)) begin
				beat.kind      = KIND_LOAD;
				shape          = $urandom_range(0, 9);
				xs             = rand_span((shape == 9) ? 0 : shape);
				ys             = rand_span((shape == 8) ? 0 : ((shape == 9) ? 8 : shape));
				{beat.left_x, beat.right_x} = xs;
				{beat.bottom_y, beat.top_y} = ys;
			end else begin
				beat.kind = KIND_CLICK;
				// mostly aim at a stored window, its edges and just past them
				if (win_count != 0 && $urandom_range(0, 99) < 75) begin
					k            = $urandom_range(0, int'(win_count) - 1);
					beat.point_x = pick_near(win_rect[k].left_x, win_rect[k].right_x);
					beat.point_y = pick_near(win_rect[k].bottom_y, win_rect[k].top_y);
				end
			end
			offer_beat(beat, 1'b0, want);
		end
		cmd_valid <= 1'b0;

		// drain, then let the block settle
		while (awaited_q.size() != 0)
			@(posedge clk);
		repeat (2 * NWIN + 8) @(posedge clk);
		if (mismatches == 0)
			$display("topmost_window_hit_test_core: match");
		else
			$display("topmost_window_hit_test_core: mismatch");
		$finish;
	end

	// Result side: check each beat, stall on a changing pattern, one long hold-off
	initial begin
		int unsigned rx_cyc;
		int unsigned hold_left;
		rx_mode_e    rx_mode;
		bit          held;
		tmwht_rsp_t  want;
		rx_cyc    = 0;
		hold_left = 0;
		held      = 1'b0;
		rx_mode   = RX_OPEN;
		res_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && res_valid && res_ready) begin
				if (awaited_q.size() == 0) begin
					report_mismatch("result beat with nothing pending, status", res.status, 0);
				end else begin
					want = awaited_q.pop_front();
					if (res.status !== want.status)
						report_mismatch("status", res.status, want.status);
					if (res.window_number !== want.window_number)
						report_mismatch("window_number", res.window_number,
						                want.window_number);
				end
			end
			rx_cyc++;
			if (rx_cyc % 97 == 0)
				rx_mode = rx_mode_e'($urandom_range(0, 2));
			if (!held && cmd_beats >= HOLD_AT) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_OPEN:   res_ready <= 1'b1;
					RX_COIN:   res_ready <= 1'($urandom());
					RX_SPARSE: res_ready <= (rx_cyc % 4 == 0);
					default:   res_ready <= 1'b1;
				endcase
			end
		end
	end

	// Watchdog: cycles with no beat on either channel
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && cmd_ready) || (res_valid && res_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		wait (idle_cycles >= IDLE_LIMIT);
		$display("%0t: watchdog, no beat for %0d cycles", $time, IDLE_LIMIT);
		$display("topmost_window_hit_test_core: mismatch");
		$finish;
	end

endmodule
